FILE: rtl/thc_pkg.sv
// Shared types and constants for the heater controller with run-time countdown.
`timescale 1ns / 1ps

package thc_pkg;

    // Defaults and fixed limits
    localparam int TICKS_PER_SECOND_DEF = 5;
    localparam logic [3:0] MAX_HOURS    = 4'd6;
    localparam logic [9:0] DEG_MAX      = 10'd999;
    localparam logic [5:0] SEC_MAX      = 6'd59;
    localparam logic [2:0] TENS_MAX     = 3'd5;
    localparam logic [3:0] UNITS_MAX    = 4'd9;

    // Converter word layout
    localparam int SENSOR_OPEN_BIT = 2;
    localparam int SENSOR_MSB      = 14;
    localparam int SENSOR_LSB      = 5;

    // Register reset values
    localparam logic [7:0] UPPER_RESET  = 8'd40;
    localparam logic [7:0] LOWER_RESET  = 8'd30;
    localparam logic [4:0] OFFSET_RESET = 5'd0;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_GO     = 2'd2,
        ACT_LOAD   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_UPPER  = 2'd0,
        CFG_LOWER  = 2'd1,
        CFG_OFFSET = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_action     action;
        logic [15:0] sensor_word;
        logic [2:0]  load_hours;
        logic [2:0]  load_tens;
        logic [3:0]  load_units;
    } t_item;

    typedef struct packed {
        logic [7:0]        upper_limit;
        logic [7:0]        lower_limit;
        logic signed [4:0] sensor_offset;
    } t_cfg;

    typedef struct packed {
        logic       running;
        logic       heater_on;
        logic       timing;
        logic       probe_open;
        logic [9:0] degrees;
        logic [2:0] left_hours;
        logic [2:0] left_tens;
        logic [3:0] left_units;
        logic [5:0] left_seconds;
    } t_result;

endpackage

FILE: rtl/thc_cfg.sv
// Configuration registers: limits and sensor offset.
`timescale 1ns / 1ps

module thc_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output thc_pkg::t_cfg       o_cfg
);

    thc_pkg::t_cfg r_cfg;

    // Register write; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_limit   <= thc_pkg::UPPER_RESET;
            r_cfg.lower_limit   <= thc_pkg::LOWER_RESET;
            r_cfg.sensor_offset <= thc_pkg::OFFSET_RESET;
        end else if (i_cfg_valid) begin
            unique case (thc_pkg::t_cfg_index'(i_cfg_index))
                thc_pkg::CFG_UPPER:  r_cfg.upper_limit   <= i_cfg_data;
                thc_pkg::CFG_LOWER:  r_cfg.lower_limit   <= i_cfg_data;
                thc_pkg::CFG_OFFSET: r_cfg.sensor_offset <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/thc_in_stage.sv
// Input register holding one accepted transaction for the update logic.
`timescale 1ns / 1ps

module thc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  thc_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output thc_pkg::t_item o_item
);

    logic           r_valid;
    thc_pkg::t_item r_item;

    // Free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/thc_core.sv
// Controller state and its combinational update for one event.
`timescale 1ns / 1ps

module thc_core #(
    parameter int TICKS_PER_SECOND = thc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  thc_pkg::t_item   i_item,
    input  thc_pkg::t_cfg    i_cfg,
    output thc_pkg::t_result o_result
);

    localparam int PW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PW-1:0] PRESCALE_LAST = PW'(TICKS_PER_SECOND - 1);

    logic          r_run, r_heat, r_timing, r_fault;
    logic [9:0]    r_temp;
    logic [PW-1:0] r_prescale;
    logic [2:0]    r_hours, r_tens;
    logic [3:0]    r_units;
    logic [5:0]    r_seconds;

    logic          n_run, n_heat, n_timing, n_fault;
    logic [9:0]    n_temp;
    logic [PW-1:0] n_prescale;
    logic [2:0]    n_hours, n_tens;
    logic [3:0]    n_units;
    logic [5:0]    n_seconds;

    logic [9:0]        w_raw;
    logic signed [11:0] w_sum;
    logic               w_zero;

    // Corrected sensor reading before clamping
    assign w_raw = i_item.sensor_word[thc_pkg::SENSOR_MSB:thc_pkg::SENSOR_LSB];
    assign w_sum = $signed({2'b00, w_raw})
                 + $signed({{7{i_cfg.sensor_offset[4]}}, i_cfg.sensor_offset});

    // Event handling followed by run evaluation
    always_comb begin
        n_run      = r_run;
        n_heat     = r_heat;
        n_timing   = r_timing;
        n_fault    = r_fault;
        n_temp     = r_temp;
        n_prescale = r_prescale;
        n_hours    = r_hours;
        n_tens     = r_tens;
        n_units    = r_units;
        n_seconds  = r_seconds;

        unique case (i_item.action)
            thc_pkg::ACT_TICK: begin
                if (r_timing) begin
                    if (r_prescale == PRESCALE_LAST) begin
                        n_prescale = '0;
                        // take one second off, borrowing downward
                        priority if (r_seconds != 6'd0) begin
                            n_seconds = r_seconds - 6'd1;
                        end else if (r_units != 4'd0) begin
                            n_units   = r_units - 4'd1;
                            n_seconds = thc_pkg::SEC_MAX;
                        end else if (r_tens != 3'd0) begin
                            n_tens    = r_tens - 3'd1;
                            n_units   = thc_pkg::UNITS_MAX;
                            n_seconds = thc_pkg::SEC_MAX;
                        end else if (r_hours != 3'd0) begin
                            n_hours   = r_hours - 3'd1;
                            n_tens    = thc_pkg::TENS_MAX;
                            n_units   = thc_pkg::UNITS_MAX;
                            n_seconds = thc_pkg::SEC_MAX;
                        end
                    end else begin
                        n_prescale = r_prescale + PW'(1);
                    end
                end
            end
            thc_pkg::ACT_SAMPLE: begin
                if (i_item.sensor_word[thc_pkg::SENSOR_OPEN_BIT]) begin
                    n_fault = 1'b1;
                end else begin
                    n_fault = 1'b0;
                    priority if (w_sum < 12'sd0) begin
                        n_temp = 10'd0;
                    end else if (w_sum > $signed({2'b00, thc_pkg::DEG_MAX})) begin
                        n_temp = thc_pkg::DEG_MAX;
                    end else begin
                        n_temp = w_sum[9:0];
                    end
                end
            end
            thc_pkg::ACT_GO: begin
                if (r_run) begin
                    n_run = 1'b0;
                end else begin
                    n_run  = 1'b1;
                    n_heat = (r_temp <= {2'b00, i_cfg.upper_limit});
                end
            end
            thc_pkg::ACT_LOAD: begin
                if (!r_run) begin
                    if ({1'b0, i_item.load_hours} >= thc_pkg::MAX_HOURS) begin
                        n_hours = thc_pkg::MAX_HOURS[2:0];
                        n_tens  = 3'd0;
                        n_units = 4'd0;
                    end else begin
                        n_hours = i_item.load_hours;
                        n_tens  = (i_item.load_tens > thc_pkg::TENS_MAX)
                                ? thc_pkg::TENS_MAX : i_item.load_tens;
                        n_units = (i_item.load_units > thc_pkg::UNITS_MAX)
                                ? thc_pkg::UNITS_MAX : i_item.load_units;
                    end
                    n_seconds = 6'd0;
                end
            end
            default: ;
        endcase

        w_zero = (n_hours == 3'd0) && (n_tens == 3'd0) && (n_units == 4'd0)
              && (n_seconds == 6'd0);

        // Run evaluation on the updated values
        if (!n_run) begin
            n_heat   = 1'b0;
            n_timing = 1'b0;
        end else if (w_zero) begin
            n_run    = 1'b0;
            n_heat   = 1'b0;
            n_timing = 1'b0;
        end else begin
            n_timing = (n_temp >= {2'b00, i_cfg.lower_limit});
            if (n_temp > {2'b00, i_cfg.upper_limit}) begin
                n_heat = 1'b0;
            end
            if (n_temp <= {2'b00, i_cfg.lower_limit}) begin
                n_heat = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_heat     <= 1'b0;
            r_timing   <= 1'b0;
            r_fault    <= 1'b0;
            r_temp     <= '0;
            r_prescale <= '0;
            r_hours    <= '0;
            r_tens     <= '0;
            r_units    <= '0;
            r_seconds  <= '0;
        end else if (i_advance) begin
            r_run      <= n_run;
            r_heat     <= n_heat;
            r_timing   <= n_timing;
            r_fault    <= n_fault;
            r_temp     <= n_temp;
            r_prescale <= n_prescale;
            r_hours    <= n_hours;
            r_tens     <= n_tens;
            r_units    <= n_units;
            r_seconds  <= n_seconds;
        end
    end

    // Result is the state after this event
    assign o_result.running      = n_run;
    assign o_result.heater_on    = n_heat;
    assign o_result.timing       = n_timing;
    assign o_result.probe_open   = n_fault;
    assign o_result.degrees      = n_temp;
    assign o_result.left_hours   = n_hours;
    assign o_result.left_tens    = n_tens;
    assign o_result.left_units   = n_units;
    assign o_result.left_seconds = n_seconds;

endmodule

FILE: rtl/thc_out_stage.sv
// Result register; holds a result until the downstream transaction completes.
`timescale 1ns / 1ps

module thc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  thc_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output thc_pkg::t_result o_result
);

    logic             r_valid;
    thc_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/thermostat_hysteresis_countdown_top.sv
// Top level of the heater controller with hysteresis and run-time countdown.
// The input register holds each transaction, then the result register holds its result.
// Throughput: one transaction per cycle while the result channel is not stalled;
// the state update is one pass of compare logic.
// Reset: synchronous active-low i_rst_n clears all flags, temperature and countdown,
// and loads the limits 40 and 30 with zero offset; no clearing pass is needed.
`timescale 1ns / 1ps

module thermostat_hysteresis_countdown_top #(
    parameter int TICKS_PER_SECOND = thc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_sensor_word,
    input  logic [2:0]  i_load_hours,
    input  logic [2:0]  i_load_tens,
    input  logic [3:0]  i_load_units,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_running,
    output logic        o_heater_on,
    output logic        o_timing,
    output logic        o_probe_open,
    output logic [9:0]  o_degrees,
    output logic [2:0]  o_left_hours,
    output logic [2:0]  o_left_tens,
    output logic [3:0]  o_left_units,
    output logic [5:0]  o_left_seconds,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    thc_pkg::t_item   w_in_item;
    thc_pkg::t_item   w_held_item;
    thc_pkg::t_cfg    w_cfg;
    thc_pkg::t_result w_next_result;
    thc_pkg::t_result w_out_result;
    logic             w_held_valid;
    logic             w_out_free;
    logic             w_advance;

    assign w_in_item.action      = thc_pkg::t_action'(i_action);
    assign w_in_item.sensor_word = i_sensor_word;
    assign w_in_item.load_hours  = i_load_hours;
    assign w_in_item.load_tens   = i_load_tens;
    assign w_in_item.load_units  = i_load_units;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    thc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    thc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    // Held transaction is processed when the result register can take it
    assign w_advance = w_held_valid && w_out_free;

    thc_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_held_item),
        .i_cfg     (w_cfg),
        .o_result  (w_next_result)
    );

    thc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_next_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (w_out_free),
        .o_result (w_out_result)
    );

    assign o_running      = w_out_result.running;
    assign o_heater_on    = w_out_result.heater_on;
    assign o_timing       = w_out_result.timing;
    assign o_probe_open   = w_out_result.probe_open;
    assign o_degrees      = w_out_result.degrees;
    assign o_left_hours   = w_out_result.left_hours;
    assign o_left_tens    = w_out_result.left_tens;
    assign o_left_units   = w_out_result.left_units;
    assign o_left_seconds = w_out_result.left_seconds;

`ifndef SYNTHESIS
    // Heater and timing only ever active within a run
    a_flags_need_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_heater_on || o_timing)) |-> o_running)
        else $error("heater or timing active outside a run");

    // A reported run always has time left
    a_run_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_running) |->
        (o_left_hours != 3'd0 || o_left_tens != 3'd0 ||
         o_left_units != 4'd0 || o_left_seconds != 6'd0))
        else $error("run reported with zero countdown");

    // Countdown seconds, tens and units digits and temperature stay in range
    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_seconds <= thc_pkg::SEC_MAX &&
                         o_left_tens <= thc_pkg::TENS_MAX &&
                         o_left_units <= thc_pkg::UNITS_MAX &&
                         o_degrees <= thc_pkg::DEG_MAX))
        else $error("countdown digit or temperature out of range");

    // Input side only blocks when a finished result is stalled downstream
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input blocked without output stall");
`endif

endmodule
